// ----- sv/seag_pkg.sv -----
// Shared types and constants for the sharded embedding address generator.
// Depends on nothing; every other file of the block imports it.
package seag_pkg;

  localparam int TOKEN_W    = 32;
  localparam int VOCAB_W    = 21;
  localparam int RANK_W     = 9;
  localparam int MYRANK_W   = 8;
  localparam int WIDTH_W    = 15;
  localparam int OWNER_W    = 8;
  localparam int LOCAL_W    = 20;
  localparam int ADDR_W     = 34;
  localparam int STRIDE_W   = 21;
  localparam int START_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int DSH_W      = VOCAB_W + OWNER_W - 1;
  localparam int PART_W     = VOCAB_W + OWNER_W;
  localparam int NUM_CELLS  = OWNER_W;
  localparam int CNT_W      = 5;
  localparam int PROD_W     = VOCAB_W + MYRANK_W;
  localparam int APROD_W    = LOCAL_W + WIDTH_W;

  localparam logic [VOCAB_W-1:0] MAX_VOCAB = VOCAB_W'(1048576);
  localparam logic [RANK_W-1:0]  MAX_RANKS = RANK_W'(256);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOCAB_COUNT       = 3'd0,
    REG_RANK_COUNT        = 3'd1,
    REG_MY_RANK           = 3'd2,
    REG_FULL_TABLE        = 3'd3,
    REG_TRANSPOSED_LAYOUT = 3'd4,
    REG_EMBEDDING_WIDTH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DRV_IDLE,
    DRV_LOAD,
    DRV_DIVIDE,
    DRV_START,
    DRV_THRESH
  } drv_state_t;

  // Settled configuration and shard bounds, as seen by the datapath.
  typedef struct packed {
    logic [VOCAB_W-1:0]  eff_vocab;
    logic [VOCAB_W-1:0]  base;
    logic [OWNER_W-1:0]  rem;
    logic [VOCAB_W-1:0]  thr;
    logic [START_W-1:0]  shard_start;
    logic [VOCAB_W-1:0]  shard_size;
    logic [VOCAB_W-1:0]  shard_end;
    logic                full_table;
    logic                transposed;
    logic [WIDTH_W-1:0]  eff_width;
  } shard_t;

  // One token on its way down the row of divider cells.
  typedef struct packed {
    logic                in_range;
    logic                served;
    logic [LOCAL_W-1:0]  local_index;
    logic [STRIDE_W-1:0] stride;
    logic [OWNER_W-1:0]  offset;
    logic [OWNER_W-1:0]  quot;
    logic [PART_W-1:0]   part;
    logic [DSH_W-1:0]    dsh;
  } item_t;

endpackage

// ----- sv/seag_in_if.sv -----
// Token channel: valid/ready handshake carrying one signed token id.
// Depends on seag_pkg.
interface seag_in_if import seag_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TOKEN_W-1:0] token;

  modport source (output valid, output token, input ready);
  modport sink   (input valid, input token, output ready);
endinterface

// ----- sv/seag_out_if.sv -----
// Result channel: valid/ready handshake carrying one lookup result.
// Depends on seag_pkg.
interface seag_out_if import seag_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                in_range;
  logic [OWNER_W-1:0]  owner_rank;
  logic                served_here;
  logic [LOCAL_W-1:0]  local_index;
  logic [ADDR_W-1:0]   row_address;
  logic [STRIDE_W-1:0] element_stride;

  modport source (output valid, output in_range, output owner_rank, output served_here,
                  output local_index, output row_address, output element_stride,
                  input ready);
  modport sink   (input valid, input in_range, input owner_rank, input served_here,
                  input local_index, input row_address, input element_stride,
                  output ready);
endinterface

// ----- sv/sharded_embedding_address_gen_unit.sv -----
// Sharded embedding address generator. Takes a token id and reports
// whether it lies in the vocabulary, the owning rank under a balanced
// block partition, whether this rank serves it, its local index, the row
// start address and the element stride. The owner rank comes from a row
// of eight divider cells, one quotient bit per cell, so a new token enters
// every cycle while results are taken and no derivation runs. After each
// configuration write the shard bounds are rederived by a serial divider
// and two multiply steps: tokens.ready stays low until that derivation
// ends. Depends on seag_pkg and the two channel interfaces.
module sharded_embedding_address_gen_unit import seag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  seag_in_if.sink               tokens,
  seag_out_if.source            results,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  shard_t shard;
  logic   idle;
  item_t  stage_item  [NUM_CELLS+1];
  logic   stage_valid [NUM_CELLS+1];
  logic   stage_ready [NUM_CELLS+1];

  seag_derive u_derive (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .shard     (shard),
    .idle      (idle)
  );

  seag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .tokens    (tokens),
    .enable    (idle),
    .shard     (shard),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_item  (stage_item[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    seag_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_item   (stage_item[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_item  (stage_item[i+1])
    );
  end

  seag_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[NUM_CELLS]),
    .in_ready (stage_ready[NUM_CELLS]),
    .in_item  (stage_item[NUM_CELLS]),
    .shard    (shard),
    .results  (results)
  );

endmodule

// ----- sv/seag_derive.sv -----
// Configuration registers and the shard derivation sequencer (serial divide
// of vocabulary by ranks, then two multiply steps). Depends on seag_pkg.
module seag_derive import seag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output shard_t                shard,
  output logic                  idle
);

  logic [VOCAB_W-1:0]  vocab_count;
  logic [RANK_W-1:0]   rank_count;
  logic [MYRANK_W-1:0] my_rank;
  logic                full_table;
  logic                transposed_layout;
  logic [WIDTH_W-1:0]  embedding_width;

  drv_state_t state, state_next;
  logic [RANK_W-1:0]  acc, acc_next;
  logic [VOCAB_W-1:0] quo, quo_next;
  logic [CNT_W-1:0]   cnt, cnt_next;

  logic [VOCAB_W-1:0] base, base_next;
  logic [OWNER_W-1:0] rem, rem_next;
  logic [VOCAB_W-1:0] thr, thr_next;
  logic [START_W-1:0] shard_start, shard_start_next;
  logic [VOCAB_W-1:0] shard_size, shard_size_next;
  logic [VOCAB_W-1:0] shard_end, shard_end_next;

  logic [VOCAB_W-1:0] eff_vocab;
  logic [RANK_W-1:0]  eff_ranks;
  logic [WIDTH_W-1:0] eff_width;
  logic [RANK_W:0]    acc_sh;
  logic               take;
  logic               rank_ok;
  logic [OWNER_W-1:0] rank_min;
  logic [PROD_W-1:0]  start_prod;
  logic [PROD_W-1:0]  thr_prod;

  assign eff_vocab = (vocab_count > MAX_VOCAB) ? MAX_VOCAB : vocab_count;
  assign eff_width = (embedding_width == '0) ? WIDTH_W'(1) :
                     (embedding_width > MAX_WIDTH) ? MAX_WIDTH : embedding_width;

  always_comb begin
    if (rank_count == '0) begin
      eff_ranks = RANK_W'(1);
    end else if (rank_count > MAX_RANKS) begin
      eff_ranks = MAX_RANKS;
    end else begin
      eff_ranks = rank_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_count       <= VOCAB_W'(1);
      rank_count        <= RANK_W'(1);
      my_rank           <= '0;
      full_table        <= 1'b0;
      transposed_layout <= 1'b0;
      embedding_width   <= WIDTH_W'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_VOCAB_COUNT:       vocab_count       <= cfg_data[VOCAB_W-1:0];
        REG_RANK_COUNT:        rank_count        <= cfg_data[RANK_W-1:0];
        REG_MY_RANK:           my_rank           <= cfg_data[MYRANK_W-1:0];
        REG_FULL_TABLE:        full_table        <= cfg_data[0];
        REG_TRANSPOSED_LAYOUT: transposed_layout <= cfg_data[0];
        REG_EMBEDDING_WIDTH:   embedding_width   <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // One restoring step of vocabulary / ranks per cycle, dividend bits enter from the top.
  assign acc_sh     = {acc, quo[VOCAB_W-1]};
  assign take       = acc_sh >= {1'b0, eff_ranks};
  assign rank_ok    = {1'b0, my_rank} < eff_ranks;
  assign rank_min   = (my_rank < rem) ? my_rank : rem;
  assign start_prod = PROD_W'(my_rank) * PROD_W'(base) + PROD_W'(rank_min);
  assign thr_prod   = PROD_W'(rem) * PROD_W'(base) + PROD_W'(rem);

  always_comb begin
    state_next       = state;
    acc_next         = acc;
    quo_next         = quo;
    cnt_next         = cnt;
    base_next        = base;
    rem_next         = rem;
    thr_next         = thr;
    shard_start_next = shard_start;
    shard_size_next  = shard_size;
    shard_end_next   = shard_end;
    case (state)
      DRV_IDLE: ;
      DRV_LOAD: begin
        acc_next   = '0;
        quo_next   = eff_vocab;
        cnt_next   = '0;
        state_next = DRV_DIVIDE;
      end
      DRV_DIVIDE: begin
        acc_next = take ? RANK_W'(acc_sh - {1'b0, eff_ranks}) : acc_sh[RANK_W-1:0];
        quo_next = {quo[VOCAB_W-2:0], take};
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(VOCAB_W - 1)) begin
          base_next  = {quo[VOCAB_W-2:0], take};
          rem_next   = acc_next[OWNER_W-1:0];
          state_next = DRV_START;
        end
      end
      DRV_START: begin
        if (rank_ok) begin
          shard_start_next = start_prod[START_W-1:0];
          shard_size_next  = (my_rank < rem) ? base + VOCAB_W'(1) : base;
        end else begin
          shard_start_next = '0;
          shard_size_next  = '0;
        end
        state_next = DRV_THRESH;
      end
      DRV_THRESH: begin
        thr_next       = thr_prod[VOCAB_W-1:0];
        shard_end_next = VOCAB_W'(shard_start) + shard_size;
        state_next     = DRV_IDLE;
      end
      default: state_next = DRV_IDLE;
    endcase
    // A write restarts the derivation from the new register values.
    if (cfg_write) begin
      state_next = DRV_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= DRV_IDLE;
      base        <= VOCAB_W'(1);
      rem         <= '0;
      thr         <= '0;
      shard_start <= '0;
      shard_size  <= VOCAB_W'(1);
      shard_end   <= VOCAB_W'(1);
    end else begin
      state       <= state_next;
      base        <= base_next;
      rem         <= rem_next;
      thr         <= thr_next;
      shard_start <= shard_start_next;
      shard_size  <= shard_size_next;
      shard_end   <= shard_end_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    quo <= quo_next;
    cnt <= cnt_next;
  end

  assign idle = (state == DRV_IDLE);

  always_comb begin
    shard.eff_vocab   = eff_vocab;
    shard.base        = base;
    shard.rem         = rem;
    shard.thr         = thr;
    shard.shard_start = shard_start;
    shard.shard_size  = shard_size;
    shard.shard_end   = shard_end;
    shard.full_table  = full_table;
    shard.transposed  = transposed_layout;
    shard.eff_width   = eff_width;
  end

endmodule

// ----- sv/seag_front.sv -----
// Entry stage: range check, shard membership, local index, stride, and the
// dividend and divisor set up for the owner division. Depends on seag_pkg.
module seag_front import seag_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  seag_in_if.sink     tokens,
  input  logic        enable,
  input  shard_t      shard,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item
);

  logic [VOCAB_W-1:0]  lo;
  logic                hi_zero;
  logic                in_range;
  logic                low_part;
  logic                served;
  logic [LOCAL_W-1:0]  local_index;
  logic [STRIDE_W-1:0] stride_sel;
  logic [STRIDE_W-1:0] stride;
  logic [VOCAB_W-1:0]  dividend;
  logic [VOCAB_W-1:0]  divisor;
  logic                accept;
  item_t               item;

  assign lo       = tokens.token[VOCAB_W-1:0];
  assign hi_zero  = (tokens.token[TOKEN_W-1:VOCAB_W] == '0);
  assign in_range = hi_zero && (lo < shard.eff_vocab);
  // Tokens below the threshold belong to ranks carrying one extra row.
  assign low_part = lo < shard.thr;
  assign served   = in_range && (shard.full_table ||
                    ((lo >= VOCAB_W'(shard.shard_start)) && (lo < shard.shard_end)));

  always_comb begin
    if (!served) begin
      local_index = '0;
    end else if (shard.full_table) begin
      local_index = lo[LOCAL_W-1:0];
    end else begin
      local_index = lo[LOCAL_W-1:0] - shard.shard_start;
    end
  end

  assign stride_sel = shard.full_table ? shard.eff_vocab : shard.shard_size;
  assign stride     = (!shard.transposed || stride_sel == '0) ? STRIDE_W'(1) : stride_sel;
  assign dividend   = low_part ? lo : lo - shard.thr;
  assign divisor    = low_part ? shard.base + VOCAB_W'(1) : shard.base;

  always_comb begin
    item.in_range    = in_range;
    item.served      = served;
    item.local_index = local_index;
    item.stride      = stride;
    item.offset      = low_part ? '0 : shard.rem;
    item.quot        = '0;
    item.part        = PART_W'(dividend);
    item.dsh         = {divisor, {(OWNER_W-1){1'b0}}};
  end

  // No transaction is taken while reset is held.
  assign tokens.ready = !rst && enable && (!out_valid || out_ready);
  assign accept       = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= item;
    end
  end

endmodule

// ----- sv/seag_cell.sv -----
// One cell of the owner divider row: settles one quotient bit and passes the
// shifted partial remainder on. Depends on seag_pkg.
module seag_cell import seag_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  logic              take;
  logic [PART_W-1:0] diff;
  logic [PART_W-1:0] kept;
  item_t             item;

  assign take = in_item.part >= PART_W'(in_item.dsh);
  assign diff = in_item.part - PART_W'(in_item.dsh);
  assign kept = take ? diff : in_item.part;

  always_comb begin
    item      = in_item;
    item.quot = {in_item.quot[OWNER_W-2:0], take};
    item.part = {kept[PART_W-2:0], 1'b0};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item;
    end
  end

endmodule

// ----- sv/seag_back.sv -----
// Output stage: owner rank from offset and quotient, row address product,
// and the result register. Depends on seag_pkg.
module seag_back import seag_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  input  shard_t      shard,
  seag_out_if.source  results
);

  logic [APROD_W-1:0] addr_prod;
  logic [ADDR_W-1:0]  addr;
  logic [OWNER_W-1:0] owner;

  assign owner     = in_item.in_range ? in_item.offset + in_item.quot : '0;
  assign addr_prod = APROD_W'(in_item.local_index) * APROD_W'(shard.eff_width);
  assign addr      = shard.transposed ? ADDR_W'(in_item.local_index) : addr_prod[ADDR_W-1:0];

  assign in_ready = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (in_ready) begin
      results.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      results.in_range       <= in_item.in_range;
      results.owner_rank     <= owner;
      results.served_here    <= in_item.served;
      results.local_index    <= in_item.local_index;
      results.row_address    <= addr;
      results.element_stride <= in_item.stride;
    end
  end

endmodule

// ----- dv/tb_sharded_embedding_address_gen_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sharded embedding address generator: a scoreboard
// predicts each lookup from the programmed shard layout. Depends on seag_pkg, the two
// channel interfaces and sharded_embedding_address_gen_unit.
module tb_sharded_embedding_address_gen_unit;
  import seag_pkg::*;

  typedef struct packed {
    logic                in_range;
    logic [OWNER_W-1:0]  owner_rank;
    logic                served_here;
    logic [LOCAL_W-1:0]  local_index;
    logic [ADDR_W-1:0]   row_address;
    logic [STRIDE_W-1:0] element_stride;
  } lookup_t;

  class lookup_scoreboard;
    logic [VOCAB_W-1:0]  vocab_reg;
    logic [RANK_W-1:0]   ranks_reg;
    logic [MYRANK_W-1:0] rank_reg;
    logic                full_reg;
    logic                trans_reg;
    logic [WIDTH_W-1:0]  width_reg;
    int unsigned eff_v, eff_r, eff_w, base, rem, thr;
    int unsigned shard_start, shard_size, shard_stop;
    lookup_t pending_lookups[$];
    int mismatches;

    function new();
      vocab_reg = 1;
      ranks_reg = 1;
      rank_reg  = 0;
      full_reg  = 0;
      trans_reg = 0;
      width_reg = 1;
      mismatches = 0;
      derive_shard();
    endfunction

    function void derive_shard();
      eff_v = (vocab_reg > MAX_VOCAB) ? MAX_VOCAB : vocab_reg;
      eff_r = (ranks_reg == 0) ? 1 : ((ranks_reg > MAX_RANKS) ? MAX_RANKS : ranks_reg);
      eff_w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      base = eff_v / eff_r;
      rem  = eff_v % eff_r;
      thr  = rem * (base + 1);
      if (rank_reg >= eff_r) begin
        shard_start = 0;
        shard_size  = 0;
      end else if (rank_reg < rem) begin
        shard_size  = base + 1;
        shard_start = rank_reg * shard_size;
      end else begin
        shard_size  = base;
        shard_start = thr + (rank_reg - rem) * base;
      end
      shard_stop = shard_start + shard_size;
    endfunction

    // Narrow registers keep only their low bits of the write data.
    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_VOCAB_COUNT:       vocab_reg = d[VOCAB_W-1:0];
        REG_RANK_COUNT:        ranks_reg = d[RANK_W-1:0];
        REG_MY_RANK:           rank_reg  = d[MYRANK_W-1:0];
        REG_FULL_TABLE:        full_reg  = d[0];
        REG_TRANSPOSED_LAYOUT: trans_reg = d[0];
        REG_EMBEDDING_WIDTH:   width_reg = d[WIDTH_W-1:0];
        default: return;
      endcase
      derive_shard();
    endfunction

    function void note_token(logic [TOKEN_W-1:0] raw);
      lookup_t e;
      int unsigned u;
      longint unsigned addr;
      int unsigned stride;
      u = raw;
      e = '0;
      e.in_range = !raw[TOKEN_W-1] && (u < eff_v);
      if (e.in_range) begin
        if (u < thr)
          e.owner_rank = OWNER_W'(u / (base + 1));
        else if (base != 0)
          e.owner_rank = OWNER_W'(rem + (u - thr) / base);
        if (full_reg) begin
          e.served_here = 1'b1;
          e.local_index = LOCAL_W'(u);
        end else if (u >= shard_start && u < shard_stop) begin
          e.served_here = 1'b1;
          e.local_index = LOCAL_W'(u - shard_start);
        end
      end
      if (e.served_here) begin
        addr = trans_reg ? longint'(e.local_index) : longint'(e.local_index) * eff_w;
        e.row_address = ADDR_W'(addr);
      end
      if (!trans_reg)
        stride = 1;
      else
        stride = full_reg ? eff_v : shard_size;
      if (stride == 0) stride = 1;
      e.element_stride = STRIDE_W'(stride);
      pending_lookups.push_back(e);
    endfunction

    function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t e;
      if (pending_lookups.size() == 0) begin
        $error("lookup result with no token outstanding");
        mismatches++;
        return;
      end
      e = pending_lookups.pop_front();
      field_check("in_range", e.in_range, got.in_range);
      field_check("owner_rank", e.owner_rank, got.owner_rank);
      field_check("served_here", e.served_here, got.served_here);
      field_check("local_index", e.local_index, got.local_index);
      field_check("row_address", e.row_address, got.row_address);
      field_check("element_stride", e.element_stride, got.element_stride);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int tx_idle;
  int rx_idle;
  lookup_scoreboard sb;

  seag_in_if  tok_if();
  seag_out_if res_if();

  sharded_embedding_address_gen_unit uut (
    .clk       (clk),
    .rst       (rst),
    .tokens    (tok_if),
    .results   (res_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: a transaction completes at an edge where valid and ready were both high.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready)
        sb.check_lookup({res_if.in_range, res_if.owner_rank, res_if.served_here,
                         res_if.local_index, res_if.row_address, res_if.element_stride});
      res_if.ready <= !rst && ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic drive_token(input logic [TOKEN_W-1:0] t);
    while ($urandom_range(99) < tx_idle) begin
      tok_if.valid <= 1'b0;
      @(posedge clk);
    end
    tok_if.valid <= 1'b1;
    tok_if.token <= t;
    do @(posedge clk); while (!tok_if.ready);
    sb.note_token(t);
  endtask

  // Every token yields exactly one result, so an empty queue means the block is idle.
  task automatic drain();
    tok_if.valid <= 1'b0;
    while (sb.pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic program_shard(input logic [CFG_DATA_W-1:0] v, r, m, f, t, w);
    write_reg(REG_VOCAB_COUNT, v);
    write_reg(REG_RANK_COUNT, r);
    write_reg(REG_MY_RANK, m);
    write_reg(REG_FULL_TABLE, f);
    write_reg(REG_TRANSPOSED_LAYOUT, t);
    write_reg(REG_EMBEDDING_WIDTH, w);
    cfg_write <= 1'b0;
  endtask

  // Mostly in-range ids, with a share aimed at the shard, partition and vocabulary edges.
  function automatic logic [TOKEN_W-1:0] pick_token();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 11 && sb.eff_v != 0) return $urandom_range(sb.eff_v - 1, 0);
    else if (sel < 13) return sb.shard_start + $urandom_range(2) - 1;
    else if (sel < 15) return sb.shard_stop + $urandom_range(2) - 1;
    else if (sel < 16) return sb.thr + $urandom_range(2) - 1;
    else if (sel < 17) return sb.eff_v + $urandom_range(2) - 1;
    else return $urandom;
  endfunction

  initial begin
    logic [TOKEN_W-1:0] dir_tokens[25] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF,
      32'd0, 32'd999, 32'd1000, 32'd428, 32'd429, 32'd571, 32'd572, 32'd857, 32'd858,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
      32'd1048575, 32'd1048576, 32'd0,
      32'd0, 32'd5,
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4};
    logic [CFG_DATA_W-1:0] fixed_cfg[4][6] = '{
      '{21'd1048576, 21'd256, 21'd255, 21'd0, 21'd0, 21'd16384},
      '{21'h1FFFFF, 21'd511, 21'd255, 21'd1, 21'd1, 21'd32767},
      '{21'd1000, 21'd7, 21'd200, 21'd0, 21'd1, 21'd5},
      '{21'd3, 21'd256, 21'd2, 21'd0, 21'd1, 21'd2}};
    int unsigned v, r, er, m, w;

    sb = new();
    tx_idle = 37;
    rx_idle = 61;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_VOCAB_COUNT;
    cfg_data  <= '0;
    tok_if.valid <= 1'b0;
    tok_if.token <= '0;
    res_if.ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset layout first, then a few hand-picked layouts.
    for (int i = 0; i < 25; i++) begin
      case (i)
        3: begin
          drain();
          program_shard(21'd1000, 21'd7, 21'd3, 21'd0, 21'd0, 21'd16384);
        end
        15: begin
          drain();
          program_shard(21'd1048576, 21'd256, 21'd255, 21'd1, 21'd0, 21'd16384);
        end
        18: begin
          drain();
          program_shard(21'd0, 21'd0, 21'd0, 21'd1, 21'd1, 21'd0);
        end
        20: begin
          drain();
          program_shard(21'd5, 21'd256, 21'd3, 21'd0, 21'd1, 21'd1);
        end
        default: ;
      endcase
      drive_token(dir_tokens[i]);
    end

    for (int p = 0; p < 24; p++) begin
      drain();
      if (p < 8) begin
        tx_idle = 37;
        rx_idle = 61;
      end else if (p < 16) begin
        tx_idle = 61;
        rx_idle = 37;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      if (p < 4) begin
        program_shard(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2],
                      fixed_cfg[p][3], fixed_cfg[p][4], fixed_cfg[p][5]);
      end else begin
        case ($urandom_range(9))
          0: v = 0;
          1: v = 1048576;
          2: v = $urandom_range(2097151, 1048577);
          3, 4: v = $urandom_range(64, 1);
          5, 6: v = $urandom_range(5000, 65);
          default: v = $urandom_range(1048576, 1);
        endcase
        case ($urandom_range(9))
          0: r = 0;
          1: r = 256;
          2: r = $urandom_range(511, 257);
          3: r = 1;
          4, 5, 6: r = $urandom_range(16, 2);
          default: r = $urandom_range(256, 2);
        endcase
        er = (r == 0) ? 1 : ((r > 256) ? 256 : r);
        m = ($urandom_range(9) < 8) ? $urandom_range(er - 1, 0) : $urandom_range(255, 0);
        case ($urandom_range(7))
          0: w = 0;
          1: w = 16384;
          2: w = $urandom_range(32767, 16385);
          3: w = 1;
          default: w = $urandom_range(16384, 1);
        endcase
        // Unused upper bits of the write data carry noise on the narrow registers.
        program_shard(CFG_DATA_W'(v), {12'($urandom), 9'(r)}, {13'($urandom), 8'(m)},
                      CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      {6'($urandom), 15'(w)});
      end
      for (int i = 0; i < 40; i++) drive_token(pick_token());
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_lookups.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
sv/seag_pkg.sv
sv/seag_in_if.sv
sv/seag_out_if.sv
sv/seag_derive.sv
sv/seag_front.sv
sv/seag_cell.sv
sv/seag_back.sv
sv/sharded_embedding_address_gen_unit.sv
dv/tb_sharded_embedding_address_gen_unit.sv
